// ===== design/assert_macros.svh =====
// Assertion macros shared by the decimator RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, muted while rst is high
`define CMMPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property check that also holds during reset
`define CMMPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/cmmpd_pkg.sv =====
// Shared constants and types for the column min/max point decimator.
// Depends on nothing; used by every module of the block.
`default_nettype none

package cmmpd_pkg;

  // Default parameter values
  localparam int TIME_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int VALUE_W   = 32;
  localparam int SCALE_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Wide multiplies: operand padded to WIDE_W, cut into MUL_W slices
  localparam int MUL_W   = 32;
  localparam int WIDE_W  = 64;
  localparam int SUM_W   = WIDE_W + MUL_W;

  // Pixel results are Q24.8
  localparam int PIX_FRAC = 8;
  // y product shift: value frac + scale frac - pixel frac
  localparam int Y_SHIFT  = 24;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [31:0] VIEW_END_RST     = 32'd65536;
  localparam logic [31:0] COLUMN_SCALE_RST = 32'd65536;
  localparam logic [31:0] X_SCALE_RST      = 32'd65536;
  localparam logic [31:0] Y_SCALE_RST      = 32'd65536;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_START,
    CFG_VIEW_END,
    CFG_COLUMN_COUNT,
    CFG_COLUMN_SCALE,
    CFG_X_SCALE,
    CFG_VALUE_MIN,
    CFG_Y_SCALE
  } cfg_index_t;

  // Back-end emit sequencer
  typedef enum logic {
    SEQ_FIRST,
    SEQ_SECOND
  } seq_state_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/column_min_max_point_decimator.sv =====
// Top level of the column min/max point decimator: configuration registers,
// stream packing, front part, job queue, back part. Depends on cmmpd_pkg,
// cmmpd_front, cmmpd_queue, cmmpd_back and assert_macros.svh.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  tdata: point_time, point_value; tuser: func
//   m_*       out   m_tvalid/m_tready  tdata: pos_x, pos_y; tlast: last_of_run
//   cfg_*     in    cfg_we             cfg_index, cfg_data
//
// Input transfers are taken every cycle; the front pipe holds 5 stages and
// stalls only while its last stage holds an item and the 4-entry queue is full.
// A column change or finish that closes an open column gives one or two results,
// one per cycle from the back pipe while m_tready takes them; a two-result job
// leaves the queue only when its second result issues.
// rst is synchronous; it clears the open column and restores register defaults.
`default_nettype none

module column_min_max_point_decimator #(
  parameter int TIME_WIDTH = cmmpd_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = cmmpd_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = ((TIME_WIDTH + cmmpd_pkg::VALUE_W + 7) / 8) * 8,
  localparam int OUT_W     = 2 * cmmpd_pkg::PIX_W,
  localparam int CFG_W     = (TIME_WIDTH > 32) ? TIME_WIDTH : 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [IN_W-1:0]                   s_tdata,  // point_time, point_value, zero pad
  input  wire logic                              s_tuser,  // func
  // result stream
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [OUT_W-1:0]                  m_tdata,  // pos_x, pos_y
  output      logic                              m_tlast,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [cmmpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_data
);

  localparam int VW = cmmpd_pkg::VALUE_W;
  localparam int XW = cmmpd_pkg::PIX_W;
  localparam int JW = 2 * TIME_WIDTH + 2 * VW;

  // Configuration registers
  logic signed [TIME_WIDTH-1:0]          view_start;
  logic signed [TIME_WIDTH-1:0]          view_end;
  logic [cmmpd_pkg::COUNT_W-1:0]         column_count;
  logic [cmmpd_pkg::SCALE_W-1:0]         column_scale;
  logic [cmmpd_pkg::SCALE_W-1:0]         x_scale;
  logic signed [VW-1:0]                  value_min;
  logic [cmmpd_pkg::SCALE_W-1:0]         y_scale;

  // Queue links
  logic                                  q_push;
  logic                                  q_pop;
  logic [JW-1:0]                         q_push_data;
  logic [JW-1:0]                         q_head;
  cmmpd_pkg::q_status_t                  q_stat;

  logic [XW-1:0]                         pos_x;
  logic [XW-1:0]                         pos_y;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      view_start   <= '0;
      view_end     <= TIME_WIDTH'(cmmpd_pkg::VIEW_END_RST);
      column_count <= cmmpd_pkg::COUNT_W'(1);
      column_scale <= cmmpd_pkg::COLUMN_SCALE_RST;
      x_scale      <= cmmpd_pkg::X_SCALE_RST;
      value_min    <= '0;
      y_scale      <= cmmpd_pkg::Y_SCALE_RST;
    end else if (cfg_we) begin
      case (cmmpd_pkg::cfg_index_t'(cfg_index))
        cmmpd_pkg::CFG_VIEW_START:   view_start   <= cfg_data[TIME_WIDTH-1:0];
        cmmpd_pkg::CFG_VIEW_END:     view_end     <= cfg_data[TIME_WIDTH-1:0];
        cmmpd_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data[cmmpd_pkg::COUNT_W-1:0];
        cmmpd_pkg::CFG_COLUMN_SCALE: column_scale <= cfg_data[cmmpd_pkg::SCALE_W-1:0];
        cmmpd_pkg::CFG_X_SCALE:      x_scale      <= cfg_data[cmmpd_pkg::SCALE_W-1:0];
        cmmpd_pkg::CFG_VALUE_MIN:    value_min    <= cfg_data[VW-1:0];
        cmmpd_pkg::CFG_Y_SCALE:      y_scale      <= cfg_data[cmmpd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  cmmpd_front #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (s_tuser),
    .point_time   (s_tdata[TIME_WIDTH-1:0]),
    .point_value  (s_tdata[TIME_WIDTH+VW-1:TIME_WIDTH]),
    .view_start   (view_start),
    .view_end     (view_end),
    .column_count (column_count),
    .column_scale (column_scale),
    .q_status     (q_stat),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  cmmpd_queue #(
    .DATA_W (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .status    (q_stat)
  );

  cmmpd_back #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_stat),
    .head_data   (q_head),
    .pop         (q_pop),
    .view_start  (view_start),
    .x_scale     (x_scale),
    .value_min   (value_min),
    .y_scale     (y_scale),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {pos_y, pos_x};

  // Checks
  `include "assert_macros.svh"

  // queue never written while full
  `CMMPD_ASSERT(a_no_overflow, !(q_push && q_stat.full), "job pushed into a full queue")
  // queue never read while empty
  `CMMPD_ASSERT(a_no_underflow, !(q_pop && q_stat.empty), "job popped from an empty queue")
  // input side only stalls on a full queue
  `CMMPD_ASSERT(a_stall_cause, !s_tready |-> q_stat.full, "input stalled with queue room")
  // the second point of a pair follows directly after the first
  `CMMPD_ASSERT(a_pair_adjacent, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid,
                "second point of a pair not ready behind the first")

endmodule

`default_nettype wire

// ===== design/cmmpd_queue.sv =====
// Short FIFO of flush jobs between the front and back parts.
// Depends on cmmpd_pkg for depth and status type.
`default_nettype none

module cmmpd_queue #(
  parameter int DATA_W = 160
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [DATA_W-1:0]     push_data,
  input  wire logic                  pop,
  output      logic [DATA_W-1:0]     head_data,
  output      cmmpd_pkg::q_status_t  status
);

  localparam int DEPTH = cmmpd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head_data    = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ===== design/cmmpd_front.sv =====
// Front part: takes input transfers, window check, column binning, per-column
// min/max tracking; pushes flush jobs into the queue. Depends on cmmpd_pkg.
`default_nettype none

module cmmpd_front #(
  parameter int TIME_WIDTH = cmmpd_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = cmmpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input stream
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic                                  func,
  input  wire logic signed [TIME_WIDTH-1:0]          point_time,
  input  wire logic signed [cmmpd_pkg::VALUE_W-1:0]  point_value,
  // configuration
  input  wire logic signed [TIME_WIDTH-1:0]          view_start,
  input  wire logic signed [TIME_WIDTH-1:0]          view_end,
  input  wire logic [cmmpd_pkg::COUNT_W-1:0]         column_count,
  input  wire logic [cmmpd_pkg::SCALE_W-1:0]         column_scale,
  // queue side
  input  wire cmmpd_pkg::q_status_t                  q_status,
  output      logic                                  push,
  output      logic [2*TIME_WIDTH+2*cmmpd_pkg::VALUE_W-1:0] push_data
);

  localparam int VW  = cmmpd_pkg::VALUE_W;
  localparam int CW  = cmmpd_pkg::COUNT_W;
  localparam int MW  = cmmpd_pkg::MUL_W;
  localparam int WW  = cmmpd_pkg::WIDE_W;
  localparam int SW  = cmmpd_pkg::SUM_W;
  localparam int PW  = TIME_WIDTH + MW;

  // Stage valids
  logic v0, v1, v2, v3, v4;
  logic en;

  // Stage payloads
  logic                    func0, func1, func2, func3, func4;
  logic                    win1, win2, win3, win4;
  logic signed [TIME_WIDTH-1:0] t0, t1, t2, t3, t4;
  logic signed [VW-1:0]    val0, val1, val2, val3, val4;
  logic [TIME_WIDTH-1:0]   d1;
  logic [2*MW-1:0]         plo2, phi2;
  logic [PW-1:0]           p3;
  logic [CW-1:0]           col4;

  // Column state
  logic                    column_valid;
  logic [CW-1:0]           open_column;
  logic signed [TIME_WIDTH-1:0] low_time, high_time;
  logic signed [VW-1:0]    low_value, high_value;

  // Combinational stage results
  logic                    win_c;
  logic [TIME_WIDTH-1:0]   d_c;
  logic [WW-1:0]           dpad;
  logic [2*MW-1:0]         plo_c, phi_c;
  logic [SW-1:0]           sum_c;
  logic [PW-1:0]           col_big;
  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           col_c;
  logic                    new_col;

  // Whole pipe stalls only when the state stage holds an item and the queue is full
  assign en       = !(v4 && q_status.full);
  assign in_ready = en;

  // Stage 0: window check and offset from window start
  assign win_c = (view_start < view_end) && !(t0 < view_start) && !(view_end < t0);
  assign d_c   = t0 - view_start;

  // Stage 1: offset times column scale, two slices
  assign dpad  = WW'(d1);
  assign plo_c = {{MW{1'b0}}, dpad[MW-1:0]}  * {{MW{1'b0}}, column_scale};
  assign phi_c = {{MW{1'b0}}, dpad[WW-1:MW]} * {{MW{1'b0}}, column_scale};

  // Stage 2: combine slices
  assign sum_c = {phi2, {MW{1'b0}}} + {{MW{1'b0}}, plo2};

  // Stage 3: floor to a column and clamp (a count of zero acts as one)
  assign col_big = p3 >> (2 * FRAC_BITS);
  assign cnt_m1  = (column_count == '0) ? '0 : column_count - CW'(1);
  assign col_c   = (col_big > PW'(cnt_m1)) ? cnt_m1 : col_big[CW-1:0];

  // Stage 4: column change test
  assign new_col = !column_valid || (col4 != open_column);

  always_comb begin
    push = 1'b0;
    if (en && v4) begin
      if (func4) begin
        push = column_valid;
      end else if (win4 && new_col) begin
        push = column_valid;
      end
    end
  end

  assign push_data = {high_value, high_time, low_value, low_time};

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      func0 <= func;
      t0    <= point_time;
      val0  <= point_value;

      func1 <= func0;
      t1    <= t0;
      val1  <= val0;
      win1  <= win_c;
      d1    <= d_c;

      func2 <= func1;
      t2    <= t1;
      val2  <= val1;
      win2  <= win1;
      plo2  <= plo_c;
      phi2  <= phi_c;

      func3 <= func2;
      t3    <= t2;
      val3  <= val2;
      win3  <= win2;
      p3    <= PW'(sum_c);

      func4 <= func3;
      t4    <= t3;
      val4  <= val3;
      win4  <= win3;
      col4  <= col_c;
    end
  end

  // Column valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      column_valid <= 1'b0;
    end else if (en && v4) begin
      if (func4) begin
        column_valid <= 1'b0;
      end else if (win4) begin
        column_valid <= 1'b1;
      end
    end
  end

  // Kept extremes; strict compares keep the first seen on ties
  always_ff @(posedge clk) begin
    if (en && v4 && !func4 && win4) begin
      if (new_col) begin
        open_column <= col4;
        low_time    <= t4;
        high_time   <= t4;
        low_value   <= val4;
        high_value  <= val4;
      end else begin
        if (val4 < low_value) begin
          low_value <= val4;
          low_time  <= t4;
        end
        if (val4 > high_value) begin
          high_value <= val4;
          high_time  <= t4;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cmmpd_back.sv =====
// Back part: orders each flush job in time, maps points to pixel offsets,
// drives the output register. Depends on cmmpd_pkg.
`default_nettype none

module cmmpd_back #(
  parameter int TIME_WIDTH = cmmpd_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = cmmpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // queue side
  input  wire cmmpd_pkg::q_status_t                  q_status,
  input  wire logic [2*TIME_WIDTH+2*cmmpd_pkg::VALUE_W-1:0] head_data,
  output      logic                                  pop,
  // configuration
  input  wire logic signed [TIME_WIDTH-1:0]          view_start,
  input  wire logic [cmmpd_pkg::SCALE_W-1:0]         x_scale,
  input  wire logic signed [cmmpd_pkg::VALUE_W-1:0]  value_min,
  input  wire logic [cmmpd_pkg::SCALE_W-1:0]         y_scale,
  // result stream
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [cmmpd_pkg::PIX_W-1:0]           pos_x,
  output      logic [cmmpd_pkg::PIX_W-1:0]           pos_y,
  output      logic                                  last_of_run
);

  localparam int VW  = cmmpd_pkg::VALUE_W;
  localparam int MW  = cmmpd_pkg::MUL_W;
  localparam int WW  = cmmpd_pkg::WIDE_W;
  localparam int SW  = cmmpd_pkg::SUM_W;
  localparam int XW  = cmmpd_pkg::PIX_W;
  localparam int PW  = TIME_WIDTH + MW;
  localparam int YPW = 2 * MW;

  // Saturate a magnitude to a signed pixel offset
  function automatic logic [XW-1:0] sat_pix(input logic neg, input logic hi_nz,
                                            input logic [XW-1:0] lo);
    logic [XW-1:0] r;
    if (neg) begin
      if (hi_nz || (lo[XW-1] && (lo[XW-2:0] != '0))) begin
        r = {1'b1, {(XW-1){1'b0}}};
      end else begin
        r = -lo;
      end
    end else begin
      if (hi_nz || lo[XW-1]) begin
        r = {1'b0, {(XW-1){1'b1}}};
      end else begin
        r = lo;
      end
    end
    return r;
  endfunction

  cmmpd_pkg::seq_state_t seq, seq_next;

  logic en;
  logic issue;

  // Job fields at the queue head
  logic signed [TIME_WIDTH-1:0] lt, ht;
  logic signed [VW-1:0]         lv, hv;
  logic                         high_first;
  logic                         two_pts;

  // Sequencer outputs
  logic signed [TIME_WIDTH-1:0] sel_t;
  logic signed [VW-1:0]         sel_v;
  logic                         sel_last;

  // Stage registers
  logic                         bv0, bv1, bv2, bv3;
  logic signed [TIME_WIDTH-1:0] t0;
  logic signed [VW-1:0]         v0;
  logic                         last0, last1, last2, last3;
  logic                         xneg1, xneg2, xneg3;
  logic                         yneg1, yneg2, yneg3;
  logic [TIME_WIDTH-1:0]        dx1;
  logic [VW:0]                  vm1;
  logic [2*MW-1:0]              xlo2, xhi2;
  logic [YPW-1:0]               py2, py3;
  logic [PW-1:0]                px3;

  // Combinational stage results
  logic                         xneg_c;
  logic [TIME_WIDTH-1:0]        dx_c;
  logic signed [VW:0]           dv_c;
  logic [VW:0]                  vm_c;
  logic [WW-1:0]                dpad;
  logic [2*MW-1:0]              xlo_c, xhi_c;
  logic [YPW:0]                 py_c;
  logic [SW-1:0]                sx_c;
  logic [PW-1:0]                magx;
  logic [YPW-1:0]               magy;

  // Whole back pipe moves when the output register is free or being taken
  assign en = !out_valid || out_ready;

  // Split the queue head
  assign lt = head_data[TIME_WIDTH-1:0];
  assign lv = head_data[TIME_WIDTH+VW-1:TIME_WIDTH];
  assign ht = head_data[2*TIME_WIDTH+VW-1:TIME_WIDTH+VW];
  assign hv = head_data[2*TIME_WIDTH+2*VW-1:2*TIME_WIDTH+VW];

  // Time order and point count of the job
  assign high_first = (ht < lt);
  assign two_pts    = high_first || (ht != lt) || (hv != lv);

  assign issue = en && !q_status.empty;

  // Sequencer next state
  always_comb begin
    seq_next = seq;
    if (issue) begin
      case (seq)
        cmmpd_pkg::SEQ_FIRST:  seq_next = two_pts ? cmmpd_pkg::SEQ_SECOND : cmmpd_pkg::SEQ_FIRST;
        cmmpd_pkg::SEQ_SECOND: seq_next = cmmpd_pkg::SEQ_FIRST;
        default:               seq_next = cmmpd_pkg::SEQ_FIRST;
      endcase
    end
  end

  // Sequencer outputs
  always_comb begin
    case (seq)
      cmmpd_pkg::SEQ_SECOND: begin
        sel_t    = high_first ? lt : ht;
        sel_v    = high_first ? lv : hv;
        sel_last = 1'b1;
        pop      = issue;
      end
      default: begin
        sel_t    = high_first ? ht : lt;
        sel_v    = high_first ? hv : lv;
        sel_last = !two_pts;
        pop      = issue && !two_pts;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= cmmpd_pkg::SEQ_FIRST;
    end else begin
      seq <= seq_next;
    end
  end

  // Stage 1: signed offsets and magnitudes
  assign xneg_c = (t0 < view_start);
  assign dx_c   = xneg_c ? view_start - t0 : t0 - view_start;
  assign dv_c   = {v0[VW-1], v0} - {value_min[VW-1], value_min};
  assign vm_c   = dv_c[VW] ? -dv_c : dv_c;

  // Stage 2: scale products
  assign dpad  = WW'(dx1);
  assign xlo_c = {{MW{1'b0}}, dpad[MW-1:0]}  * {{MW{1'b0}}, x_scale};
  assign xhi_c = {{MW{1'b0}}, dpad[WW-1:MW]} * {{MW{1'b0}}, x_scale};
  assign py_c  = {{(YPW-VW){1'b0}}, vm1} * {{(YPW+1-MW){1'b0}}, y_scale};

  // Stage 3: combine x slices
  assign sx_c = {xhi2, {MW{1'b0}}} + {{MW{1'b0}}, xlo2};

  // Stage 4: drop to Q24.8
  assign magx = px3 >> (FRAC_BITS + cmmpd_pkg::PIX_FRAC);
  assign magy = py3 >> cmmpd_pkg::Y_SHIFT;

  // Valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bv0       <= 1'b0;
      bv1       <= 1'b0;
      bv2       <= 1'b0;
      bv3       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      bv0       <= issue;
      bv1       <= bv0;
      bv2       <= bv1;
      bv3       <= bv2;
      out_valid <= bv3;
    end
  end

  // Payload pipeline and output register
  always_ff @(posedge clk) begin
    if (en) begin
      t0    <= sel_t;
      v0    <= sel_v;
      last0 <= sel_last;

      xneg1 <= xneg_c;
      dx1   <= dx_c;
      yneg1 <= dv_c[VW];
      vm1   <= vm_c;
      last1 <= last0;

      xneg2 <= xneg1;
      yneg2 <= yneg1;
      xlo2  <= xlo_c;
      xhi2  <= xhi_c;
      py2   <= py_c[YPW-1:0];
      last2 <= last1;

      xneg3 <= xneg2;
      yneg3 <= yneg2;
      px3   <= PW'(sx_c);
      py3   <= py2;
      last3 <= last2;

      pos_x       <= sat_pix(xneg3, magx[PW-1:XW] != '0, magx[XW-1:0]);
      pos_y       <= sat_pix(yneg3, magy[YPW-1:XW] != '0, magy[XW-1:0]);
      last_of_run <= last3;
    end
  end

endmodule

`default_nettype wire
